### rtl/sts_pkg.sv
// Shared types, widths and helpers for the fixed-point sine series core.
// Depends on nothing; the core imports it by wildcard.
`timescale 1ns / 1ps

package sts_pkg;

   // Port widths.
   localparam int ANG_W   = 9;
   localparam int TC_W    = 4;
   localparam int OUT_W   = 16;
   localparam int DATA_W  = 16;

   // Internal Q.26 datapath widths, sized for angles of -256..255 degrees.
   localparam int INT_FRAC    = 26;
   localparam int A_W         = 10;
   localparam int RAD_W       = 21;
   localparam int X_W         = 29;
   localparam int XX_W        = 58;
   localparam int X2_W        = 31;
   localparam int T_W         = 31;
   localparam int S_W         = 33;
   localparam int P_W         = 62;
   localparam int Q_W         = 36;
   localparam int QH_W        = 18;
   localparam int R_W         = 34;
   localparam int PP_W        = 52;
   localparam int RECIP_SHIFT = 36;

   // round(pi / 180 * 2^26)
   localparam logic [RAD_W-1:0] RAD_PER_DEG = 21'd1171271;
   localparam logic [TC_W-1:0]  TERM_RESET  = 4'd8;

   // Control and shared payload that travel down the term pipeline.
   typedef struct packed {
      logic                   valid;
      logic                   neg;
      logic [TC_W-1:0]        terms;
      logic [X2_W-1:0]        x2;
      logic signed [S_W-1:0]  sum;
   } carry_type;

   // Adds or subtracts term number k (odd terms add) when k is within the term count.
   function automatic logic signed [S_W-1:0] acc_term(
      input logic signed [S_W-1:0] sum,
      input logic [T_W-1:0]        t,
      input logic [TC_W-1:0]       k,
      input logic [TC_W-1:0]       n
   );
      logic signed [S_W-1:0] ts;
      ts = $signed({{(S_W-T_W){1'b0}}, t});
      if (k > n) begin
         return sum;
      end else if (k[0]) begin
         return sum + ts;
      end else begin
         return sum - ts;
      end
   endfunction

endpackage

### rtl/sine_taylor_series_core.sv
// Sine of an angle in whole degrees by a truncated Taylor series, Q3.12 result.
// Throughput: one beat per cycle unless a stalled output beat holds the pipeline.
// Each series term after the first adds five register stages.
// A stalled output beat freezes the whole pipeline, so nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits and sets term_count to 8.
`timescale 1ns / 1ps

module sine_taylor_series_core import sts_pkg::*; #(
   parameter int MAX_TERMS     = 8,
   parameter int OUT_FRAC_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [8:0] angle_deg (signed), [15:9] zero fill
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [15:0] series_sum (signed Q3.12)
   input  logic              csr_wr_en,
   input  logic [TC_W-1:0]   csr_wr_data  // term_count
);

   // Right shift that takes the Q.26 sum down to the output format.
   localparam int SH = INT_FRAC - OUT_FRAC_BITS;
   localparam logic [S_W:0] POS_LIMIT = (S_W+1)'(2**(OUT_W-1) - 1);
   localparam logic [S_W:0] NEG_LIMIT = (S_W+1)'(2**(OUT_W-1));

   // The only configuration register: the number of series terms.
   logic [TC_W-1:0] term_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= TERM_RESET;
      end else if (csr_wr_en) begin
         term_count_ff <= csr_wr_data;
      end
   end

   // Every stage moves together. The pipeline only halts when the output
   // register holds a beat that the consumer does not take.
   logic adv;
   logic rsp_tvalid_ff;
   logic [OUT_W-1:0] rsp_tdata_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ------------------------------------------------------------------
   // Front end: magnitude of the angle, conversion to radians, x squared.
   // The series has only odd powers, so it runs on |angle| and the sign
   // is put back on the finished sum.
   // ------------------------------------------------------------------
   logic [TC_W-1:0]  terms_clamped;
   logic [A_W-1:0]   angle_ext;
   carry_type        f0_carry_in, f0_carry_ff;
   logic [A_W-1:0]   f0_a_in, f0_a_ff;
   carry_type        f1_carry_ff;
   logic [X_W-1:0]   f1_x_in, f1_x_ff;
   carry_type        f2_carry_ff;
   logic [X_W-1:0]   f2_x_ff;
   logic [XX_W-1:0]  f2_xx_in, f2_xx_ff;
   carry_type        f3_carry_in, f3_carry_ff;
   logic [T_W-1:0]   f3_t_ff;
   logic [XX_W-1:0]  f3_rnd;

   // Term counts above MAX_TERMS, the number of series terms built, fall back to MAX_TERMS.
   assign terms_clamped = (term_count_ff > TC_W'(MAX_TERMS)) ? TC_W'(MAX_TERMS)
                                                             : term_count_ff;
   assign angle_ext = {req_tdata[ANG_W-1], req_tdata[ANG_W-1:0]};

   always_comb begin
      f0_carry_in.valid = req_tvalid;
      f0_carry_in.neg   = req_tdata[ANG_W-1];
      f0_carry_in.terms = terms_clamped;
      f0_carry_in.x2    = '0;
      f0_carry_in.sum   = '0;
      f0_a_in = req_tdata[ANG_W-1] ? A_W'(~angle_ext + A_W'(1)) : angle_ext;
   end

   assign f1_x_in  = X_W'(f0_a_ff) * X_W'(RAD_PER_DEG);
   assign f2_xx_in = XX_W'(f1_x_ff) * XX_W'(f1_x_ff);
   assign f3_rnd   = f2_xx_ff + (XX_W'(1) << (INT_FRAC - 1));

   always_comb begin
      f3_carry_in    = f2_carry_ff;
      f3_carry_in.x2 = X2_W'(f3_rnd >> INT_FRAC);
      f3_carry_in.sum = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_carry_ff.valid <= 1'b0;
         f1_carry_ff.valid <= 1'b0;
         f2_carry_ff.valid <= 1'b0;
         f3_carry_ff.valid <= 1'b0;
      end else if (adv) begin
         f0_carry_ff <= f0_carry_in;
         f0_a_ff     <= f0_a_in;
         f1_carry_ff <= f0_carry_ff;
         f1_x_ff     <= f1_x_in;
         f2_carry_ff <= f1_carry_ff;
         f2_x_ff     <= f1_x_ff;
         f2_xx_ff    <= f2_xx_in;
         f3_carry_ff <= f3_carry_in;
         f3_t_ff     <= T_W'(f2_x_ff);
      end
   end

   // ------------------------------------------------------------------
   // Term pipeline. Slot j builds term k = j + 2 from term k - 1:
   //   t_k = round(t_(k-1) * x2 / (d * 2^26)), d = (2k-2)(2k-1).
   // Sub-stage A multiplies and adds the previous term into the sum,
   // B adds the rounding offset and drops 26 bits, C and D multiply by a
   // fixed reciprocal of d in two halves, and E corrects the estimate,
   // which is at most one low, by one compare and subtract.
   // ------------------------------------------------------------------
   carry_type      hand_carry [MAX_TERMS];
   logic [T_W-1:0] hand_t     [MAX_TERMS];

   assign hand_carry[0] = f3_carry_ff;
   assign hand_t[0]     = f3_t_ff;

   for (genvar j = 0; j < MAX_TERMS - 1; j++) begin : g_term
      localparam int K = j + 2;
      localparam longint unsigned DIV   = longint'((2*K - 2) * (2*K - 1));
      localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / DIV;
      localparam logic [R_W-1:0]  RECIP_V = R_W'(RECIP);
      localparam logic [Q_W-1:0]  DIV_Q   = Q_W'(DIV);

      carry_type          a_carry_in, a_carry_ff;
      logic [P_W-1:0]     a_prod_in, a_prod_ff;
      carry_type          b_carry_ff;
      logic [P_W:0]       b_rnd;
      logic [Q_W-1:0]     b_q_in, b_q_ff;
      carry_type          c_carry_ff;
      logic [Q_W-1:0]     c_q_ff;
      logic [PP_W-1:0]    c_plo_in, c_plo_ff, c_phi_in, c_phi_ff;
      carry_type          d_carry_ff;
      logic [Q_W-1:0]     d_q_ff;
      logic [PP_W+QH_W:0] d_tot;
      logic [T_W-1:0]     d_est_in, d_est_ff;
      carry_type          e_carry_ff;
      logic [Q_W-1:0]     e_rem;
      logic [T_W-1:0]     e_t_in, e_t_ff;

      always_comb begin
         a_carry_in     = hand_carry[j];
         a_carry_in.sum = acc_term(hand_carry[j].sum, hand_t[j], TC_W'(K - 1),
                                   hand_carry[j].terms);
      end

      assign a_prod_in = P_W'(hand_t[j]) * P_W'(hand_carry[j].x2);
      assign b_rnd     = {1'b0, a_prod_ff} + (P_W+1)'(DIV << (INT_FRAC - 1));
      assign b_q_in    = b_rnd[INT_FRAC +: Q_W];
      assign c_plo_in  = PP_W'(b_q_ff[QH_W-1:0]) * PP_W'(RECIP_V);
      assign c_phi_in  = PP_W'(b_q_ff[Q_W-1:QH_W]) * PP_W'(RECIP_V);
      assign d_tot     = {1'b0, c_phi_ff, {QH_W{1'b0}}} + (PP_W+QH_W+1)'(c_plo_ff);
      assign d_est_in  = d_tot[RECIP_SHIFT +: T_W];
      assign e_rem     = d_q_ff - Q_W'(Q_W'(d_est_ff) * DIV_Q);
      assign e_t_in    = (e_rem >= DIV_Q) ? d_est_ff + T_W'(1) : d_est_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            a_carry_ff.valid <= 1'b0;
            b_carry_ff.valid <= 1'b0;
            c_carry_ff.valid <= 1'b0;
            d_carry_ff.valid <= 1'b0;
            e_carry_ff.valid <= 1'b0;
         end else if (adv) begin
            a_carry_ff <= a_carry_in;
            a_prod_ff  <= a_prod_in;
            b_carry_ff <= a_carry_ff;
            b_q_ff     <= b_q_in;
            c_carry_ff <= b_carry_ff;
            c_q_ff     <= b_q_ff;
            c_plo_ff   <= c_plo_in;
            c_phi_ff   <= c_phi_in;
            d_carry_ff <= c_carry_ff;
            d_q_ff     <= c_q_ff;
            d_est_ff   <= d_est_in;
            e_carry_ff <= d_carry_ff;
            e_t_ff     <= e_t_in;
         end
      end

      assign hand_carry[j+1] = e_carry_ff;
      assign hand_t[j+1]     = e_t_ff;
   end

   // ------------------------------------------------------------------
   // Back end: add the last term, take the magnitude, round half away
   // from zero to the output format and saturate.
   // ------------------------------------------------------------------
   carry_type      fin_carry_in, fin_carry_ff;
   logic           o1_valid_ff;
   logic           o1_neg_in, o1_neg_ff;
   logic [S_W-1:0] o1_mag_in, o1_mag_ff;
   logic [S_W:0]   o2_rnd;
   logic [S_W:0]   o2_r;
   logic [OUT_W-1:0] rsp_tdata_in;

   always_comb begin
      fin_carry_in     = hand_carry[MAX_TERMS-1];
      fin_carry_in.sum = acc_term(hand_carry[MAX_TERMS-1].sum, hand_t[MAX_TERMS-1],
                                  TC_W'(MAX_TERMS), hand_carry[MAX_TERMS-1].terms);
   end

   // The angle sign and the sign of the magnitude sum combine into the result sign.
   assign o1_neg_in = fin_carry_ff.sum[S_W-1] ^ fin_carry_ff.neg;
   assign o1_mag_in = fin_carry_ff.sum[S_W-1] ? S_W'(-fin_carry_ff.sum)
                                              : S_W'(fin_carry_ff.sum);

   assign o2_rnd = (S_W+1)'(o1_mag_ff) + ((S_W+1)'(1) << (SH - 1));
   assign o2_r   = o2_rnd >> SH;

   always_comb begin
      if (o1_neg_ff) begin
         if (o2_r > NEG_LIMIT) begin
            rsp_tdata_in = {1'b1, {(OUT_W-1){1'b0}}};
         end else begin
            rsp_tdata_in = OUT_W'((S_W+1)'(0) - o2_r);
         end
      end else begin
         if (o2_r > POS_LIMIT) begin
            rsp_tdata_in = OUT_W'(POS_LIMIT);
         end else begin
            rsp_tdata_in = OUT_W'(o2_r);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_carry_ff.valid <= 1'b0;
         o1_valid_ff        <= 1'b0;
         rsp_tvalid_ff      <= 1'b0;
      end else if (adv) begin
         fin_carry_ff  <= fin_carry_in;
         o1_valid_ff   <= fin_carry_ff.valid;
         o1_neg_ff     <= o1_neg_in;
         o1_mag_ff     <= o1_mag_in;
         rsp_tvalid_ff <= o1_valid_ff;
         rsp_tdata_ff  <= rsp_tdata_in;
      end
   end

`ifndef NO_ASSERTIONS
   // An accepted beat always lands in the first pipeline stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> f0_carry_ff.valid)
      else $error("accepted beat did not enter the pipeline");

   // With no terms selected nothing may be added to the sum.
   a_zero_terms: assert property (@(posedge clock) disable iff (reset)
      fin_carry_ff.valid && fin_carry_ff.terms == '0 |-> fin_carry_ff.sum == '0)
      else $error("nonzero sum with a term count of zero");

   // A zero magnitude leaves the output register as zero.
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      o1_valid_ff && adv && o1_mag_ff == '0 |=> rsp_tvalid && rsp_tdata == '0)
      else $error("zero magnitude did not produce a zero result");

   // A non-negative result never shows a set sign bit after saturation.
   a_pos_sign: assert property (@(posedge clock) disable iff (reset)
      o1_valid_ff && adv && !o1_neg_ff |=> !rsp_tdata[OUT_W-1])
      else $error("positive result came out with the sign bit set");
`endif

endmodule
